>>> design/assert_macros.svh
// Assertion macros for the comment stripper design.
// No dependencies; include from any module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property with synchronous reset disable.
`define CCS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Checked property without reset disable.
`define CCS_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define CCS_ASSERT(lbl, clk, rst, prop)
`define CCS_ASSERT_NR(lbl, clk, prop)
`endif
`endif

>>> design/ccs_pkg.sv
// Shared types and constants for the comment stripper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ccs_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_END_OK = 2'd1,
    KIND_UNTERM = 2'd2
  } kind_t;

  typedef enum logic [8:0] {
    M_NORMAL = 9'b000000001,
    M_SQ     = 9'b000000010,
    M_SQ_ESC = 9'b000000100,
    M_DQ     = 9'b000001000,
    M_DQ_ESC = 9'b000010000,
    M_SLASH  = 9'b000100000,
    M_LINE   = 9'b001000000,
    M_BLOCK  = 9'b010000000,
    M_STAR   = 9'b100000000
  } mode_t;

  // One or two results queued for the back end.
  typedef struct packed {
    logic        two;
    kind_t       k0;
    logic [7:0]  b0;
    kind_t       k1;
    logic [7:0]  b1;
    logic [31:0] eline;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t data;
  } qport_t;

endpackage
`default_nettype wire

>>> design/ccs_front.sv
// Front end: accepts bytes, runs the lexer state machine, pushes result entries.
// Depends on ccs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ccs_front #(
  parameter int LINE_BITS = 32
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                action,
  input  wire  [7:0]         in_byte,
  input  wire                q_full,
  output ccs_pkg::qport_t    push
);
  import ccs_pkg::*;

  mode_t                 mode, mode_next;
  logic [LINE_BITS-1:0]  line_count, line_count_next;
  logic [LINE_BITS-1:0]  start_line, start_line_next;
  logic [LINE_BITS+31:0] start_wide;
  logic [31:0]           start_sat;
  logic                  accept;
  logic                  emit;
  entry_t                ent;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Clamp the start line to the 32-bit result field.
  assign start_wide = {32'd0, start_line};
  assign start_sat  = (|start_wide[LINE_BITS+31:32]) ? 32'hFFFF_FFFF : start_wide[31:0];

  always_comb begin
    mode_next       = mode;
    line_count_next = line_count;
    start_line_next = start_line;
    emit            = 1'b0;
    ent.two         = 1'b0;
    ent.k0          = KIND_BYTE;
    ent.b0          = in_byte;
    ent.k1          = KIND_BYTE;
    ent.b1          = in_byte;
    ent.eline       = 32'd0;
    if (action) begin
      emit = 1'b1;
      if (mode == M_SLASH) begin
        ent.two = 1'b1;
        ent.b0  = CH_SLASH;
        ent.k1  = (mode == M_BLOCK || mode == M_STAR) ? KIND_UNTERM : KIND_END_OK;
        ent.b1  = 8'd0;
      end else if (mode == M_BLOCK || mode == M_STAR) begin
        ent.k0    = KIND_UNTERM;
        ent.b0    = 8'd0;
        ent.eline = start_sat;
      end else begin
        ent.k0 = KIND_END_OK;
        ent.b0 = 8'd0;
      end
      mode_next       = M_NORMAL;
      line_count_next = {{(LINE_BITS-1){1'b0}}, 1'b1};
      start_line_next = '0;
    end else begin
      case (mode)
        M_SQ: begin
          emit = 1'b1;
          if (in_byte == CH_SQ) mode_next = M_NORMAL;
          else if (in_byte == CH_BSL) mode_next = M_SQ_ESC;
        end
        M_SQ_ESC: begin
          emit      = 1'b1;
          mode_next = M_SQ;
        end
        M_DQ: begin
          emit = 1'b1;
          if (in_byte == CH_DQ) mode_next = M_NORMAL;
          else if (in_byte == CH_BSL) mode_next = M_DQ_ESC;
        end
        M_DQ_ESC: begin
          emit      = 1'b1;
          mode_next = M_DQ;
        end
        M_SLASH: begin
          emit = 1'b1;
          if (in_byte == CH_SLASH) begin
            mode_next = M_LINE;
            ent.b0    = CH_SPACE;
          end else if (in_byte == CH_STAR) begin
            mode_next       = M_BLOCK;
            start_line_next = line_count;
            ent.b0          = CH_SPACE;
          end else begin
            mode_next = M_NORMAL;
            ent.two   = 1'b1;
            ent.b0    = CH_SLASH;
          end
        end
        M_LINE: begin
          if (in_byte == CH_NL) begin
            emit      = 1'b1;
            mode_next = M_NORMAL;
          end
        end
        M_BLOCK: begin
          if (in_byte == CH_STAR) mode_next = M_STAR;
          else if (in_byte == CH_NL) emit = 1'b1;
        end
        M_STAR: begin
          if (in_byte == CH_SLASH) begin
            mode_next = M_NORMAL;
          end else if (in_byte != CH_STAR) begin
            emit      = (in_byte == CH_NL);
            mode_next = M_BLOCK;
          end
        end
        default: begin
          if (in_byte == CH_SLASH) begin
            mode_next = M_SLASH;
          end else begin
            emit = 1'b1;
            if (in_byte == CH_SQ) mode_next = M_SQ;
            else if (in_byte == CH_DQ) mode_next = M_DQ;
            else mode_next = M_NORMAL;
          end
        end
      endcase
      // Count lines, saturating at all ones.
      if (in_byte == CH_NL && line_count != '1)
        line_count_next = line_count + {{(LINE_BITS-1){1'b0}}, 1'b1};
    end
  end

  assign push.valid = accept && emit;
  assign push.data  = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_NORMAL;
      line_count <= {{(LINE_BITS-1){1'b0}}, 1'b1};
      start_line <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      line_count <= line_count_next;
      start_line <= start_line_next;
    end
  end

endmodule
`default_nettype wire

>>> design/ccs_queue.sv
// Small FIFO of result entries between front and back ends.
// Depends on ccs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ccs_queue (
  input  wire              clk,
  input  wire              rst,
  input  ccs_pkg::qport_t  push,
  output logic             full,
  output ccs_pkg::qport_t  head,
  input  wire              pop
);
  import ccs_pkg::*;

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_pop;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.data  = mem[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_ptr] <= push.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid)
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (do_pop)
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      if (push.valid && !do_pop) count <= count + QCNT_W'(1);
      else if (!push.valid && do_pop) count <= count - QCNT_W'(1);
    end
  end

endmodule
`default_nettype wire

>>> design/ccs_back.sv
// Back end: splits queued entries into single results and drives the output register.
// Depends on ccs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ccs_back (
  input  wire              clk,
  input  wire              rst,
  input  ccs_pkg::qport_t  head,
  output logic             pop,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       out_byte,
  output logic [31:0]      error_line,
  output logic             last
);
  import ccs_pkg::*;

  logic  phase;
  logic  load;
  logic  first_half;
  kind_t kind_q;

  assign load       = head.valid && (!out_valid || out_ready);
  assign first_half = head.data.two && !phase;
  assign pop        = load && !first_half;
  assign kind       = kind_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= first_half;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: first result of a pair, else the entry's final result.
  always_ff @(posedge clk) begin
    if (load) begin
      if (first_half) begin
        kind_q     <= head.data.k0;
        out_byte   <= head.data.b0;
        error_line <= 32'd0;
        last       <= 1'b0;
      end else if (head.data.two) begin
        kind_q     <= head.data.k1;
        out_byte   <= head.data.b1;
        error_line <= head.data.eline;
        last       <= 1'b1;
      end else begin
        kind_q     <= head.data.k0;
        out_byte   <= head.data.b0;
        error_line <= head.data.eline;
        last       <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/c_comment_stripper.sv
// C comment stripper: one byte per word in, stripped bytes and end status out.
// Results of a word go into the queue, then into the output register.
// Throughput: one word per cycle while the queue is not full; a word with two
// results (a held slash plus the next byte, or a held slash at end of stream)
// stays queued until both results leave and can fill the queue, stalling input.
// Reset: synchronous, active high; normal mode, line count one, queue empty.
`timescale 1ns / 1ps
`default_nettype none
module c_comment_stripper #(
  parameter int LINE_BITS = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         action,
  input  wire  [7:0]  in_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [31:0] error_line,
  output logic        last
);
  import ccs_pkg::*;
`include "assert_macros.svh"

  qport_t push;
  qport_t head;
  logic   q_full;
  logic   pop;

  // Front end: classify each word, update the lexer mode and line counters,
  // and push one queue entry for every word that yields output.
  ccs_front #(
    .LINE_BITS(LINE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push)
  );

  // Queue decouples the front from output stalls.
  ccs_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  // Back end: emit each entry as one or two result words.
  ccs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .out_byte   (out_byte),
    .error_line (error_line),
    .last       (last)
  );

  // End-of-stream results always close their word.
  `CCS_ASSERT(a_status_last, clk, rst, out_valid && kind != KIND_BYTE |-> last)
  // Error line is carried only by the unterminated-comment result.
  `CCS_ASSERT(a_eline_zero, clk, rst, out_valid && kind != KIND_UNTERM |-> error_line == 32'd0)
  // A first-of-pair result is always followed by its partner byte or status.
  `CCS_ASSERT(a_pair_follow, clk, rst, out_valid && out_ready && !last |=> out_valid)

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for c_comment_stripper: directed and random byte streams
// are checked word by word against a behavioral comment-stripping predictor.
// Depends on ccs_pkg (character codes, kind_t, mode_t) and the stripper RTL.
module testbench;
  import ccs_pkg::*;

  localparam logic ACT_DATA     = 1'b0;
  localparam logic ACT_END      = 1'b1;
  localparam int   CYCLE_LIMIT  = 400000;
  localparam int   RANDOM_WORDS = 500;

  typedef struct {
    kind_t       rkind;
    logic [7:0]  rbyte;
    logic [31:0] rline;
    logic        rlast;
  } strip_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  wire         in_ready;
  logic        action;
  logic [7:0]  in_byte;
  wire         out_valid;
  logic        out_ready;
  wire  [1:0]  kind;
  wire  [7:0]  out_byte;
  wire  [31:0] error_line;
  wire         last;

  // Predictor state: scanner mode, current line and start line of the open block comment.
  mode_t       scan_mode;
  logic [31:0] line_no;
  logic [31:0] block_start;

  strip_result_t step_out[$];     // results of the word being predicted
  strip_result_t expected_out[$]; // results still owed by the block

  int          errors          = 0;
  int          results_checked = 0;
  int          words_sent      = 0;
  int          streams_ended   = 0;
  int          burst_left      = 0;
  int          cycles          = 0;
  int unsigned rx_tick         = 0;

  c_comment_stripper dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_byte  (out_byte),
    .error_line(error_line),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void add_result(kind_t k, logic [7:0] b, logic [31:0] el);
    strip_result_t r;
    r.rkind = k;
    r.rbyte = b;
    r.rline = el;
    r.rlast = 1'b0;
    step_out.push_back(r);
  endfunction

  // Advance the scanner by one accepted word and queue the results it owes.
  task automatic strip_predict(input logic act, input logic [7:0] b);
    step_out.delete();
    if (act == ACT_END) begin
      // Flush a held slash first, then report how the stream ended.
      if (scan_mode == M_SLASH) add_result(KIND_BYTE, CH_SLASH, '0);
      if (scan_mode == M_BLOCK || scan_mode == M_STAR) add_result(KIND_UNTERM, 8'h00, block_start);
      else add_result(KIND_END_OK, 8'h00, '0);
      scan_mode   = M_NORMAL;
      line_no     = 32'd1;
      block_start = '0;
    end else begin
      case (scan_mode)
        M_SQ: begin
          if (b == CH_SQ) scan_mode = M_NORMAL;
          else if (b == CH_BSL) scan_mode = M_SQ_ESC;
          add_result(KIND_BYTE, b, '0);
        end
        M_SQ_ESC: begin
          add_result(KIND_BYTE, b, '0);
          scan_mode = M_SQ;
        end
        M_DQ: begin
          if (b == CH_DQ) scan_mode = M_NORMAL;
          else if (b == CH_BSL) scan_mode = M_DQ_ESC;
          add_result(KIND_BYTE, b, '0);
        end
        M_DQ_ESC: begin
          add_result(KIND_BYTE, b, '0);
          scan_mode = M_DQ;
        end
        M_SLASH: begin
          if (b == CH_SLASH) begin
            scan_mode = M_LINE;
            add_result(KIND_BYTE, CH_SPACE, '0);
          end else if (b == CH_STAR) begin
            scan_mode   = M_BLOCK;
            block_start = line_no;
            add_result(KIND_BYTE, CH_SPACE, '0);
          end else begin
            // Not a comment after all: release the slash, then the byte.
            scan_mode = M_NORMAL;
            add_result(KIND_BYTE, CH_SLASH, '0);
            add_result(KIND_BYTE, b, '0);
          end
        end
        M_LINE: begin
          if (b == CH_NL) begin
            scan_mode = M_NORMAL;
            add_result(KIND_BYTE, CH_NL, '0);
          end
        end
        M_BLOCK: begin
          if (b == CH_STAR) scan_mode = M_STAR;
          else if (b == CH_NL) add_result(KIND_BYTE, CH_NL, '0);
        end
        M_STAR: begin
          if (b == CH_SLASH) begin
            scan_mode = M_NORMAL;
          end else if (b != CH_STAR) begin
            if (b == CH_NL) add_result(KIND_BYTE, CH_NL, '0);
            scan_mode = M_BLOCK;
          end
        end
        default: begin
          if (b == CH_SQ) scan_mode = M_SQ;
          else if (b == CH_DQ) scan_mode = M_DQ;
          else if (b == CH_SLASH) scan_mode = M_SLASH;
          else scan_mode = M_NORMAL;
          if (b != CH_SLASH) add_result(KIND_BYTE, b, '0);
        end
      endcase
      // Count lines in every mode; hold at the top value.
      if (b == CH_NL && line_no != '1) line_no++;
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].rlast = 1'b1;
    foreach (step_out[i]) expected_out.push_back(step_out[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic act, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    action   <= act;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (act == ACT_END) streams_ended++;
    strip_predict(act, b);
  endtask

  task automatic send_data(input logic [7:0] b);
    send_word(ACT_DATA, b);
  endtask

  // Hold the sender off until every owed result has come back.
  task automatic wait_for_drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_out.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: cycle through always-ready, random and sparse stall phases
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_tick[9:8])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= (rx_tick[2:0] == 3'd0);
      default: out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  function automatic void report_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    errors++;
    $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, field, want_v, got_v);
  endfunction

  always @(posedge clk) begin : check_results
    strip_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result: expected none, actual kind %0d byte %02h line %0d",
                 $time, kind, out_byte, error_line);
      end else begin
        want = expected_out.pop_front();
        results_checked++;
        if (kind !== want.rkind) report_field("kind", want.rkind, kind);
        if (out_byte !== want.rbyte) report_field("out_byte", want.rbyte, out_byte);
        if (error_line !== want.rline) report_field("error_line", want.rline, error_line);
        if (last !== want.rlast) report_field("last", want.rlast, last);
      end
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, expected_out.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Random stream pieces
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] code_char();
    case ($urandom_range(0, 7))
      0:       return CH_NL;
      1:       return CH_SPACE;
      2:       return CH_STAR;
      3:       return 8'h3B; // semicolon
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // Quoted literal with random body and backslash escapes of any byte.
  task automatic send_literal(input logic [7:0] quote);
    logic [7:0] c;
    send_data(quote);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 3) == 0) begin
        send_data(CH_BSL);
        send_data(any_byte());
      end else begin
        c = any_byte();
        if (c == quote || c == CH_BSL) c = 8'h78;
        send_data(c);
      end
    end
    send_data(quote);
  endtask

  task automatic send_block_comment();
    send_data(CH_SLASH);
    send_data(CH_STAR);
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 4))
        0:       send_data(CH_STAR);
        1:       send_data(CH_NL);
        2:       send_data(any_byte());
        default: send_data(code_char());
      endcase
    end
    repeat ($urandom_range(1, 3)) send_data(CH_STAR);
    send_data(CH_SLASH);
  endtask

  // One stream of code-like fragments, mostly well formed, closed by an end word.
  task automatic send_random_stream();
    logic [7:0] c;
    repeat ($urandom_range(2, 20)) begin
      case ($urandom_range(0, 9))
        2: send_literal(CH_DQ);
        3: send_literal(CH_SQ);
        4: begin
          send_data(CH_SLASH);
          send_data(CH_SLASH);
          repeat ($urandom_range(0, 10)) begin
            c = any_byte();
            if (c == CH_NL) c = CH_SPACE;
            send_data(c);
          end
          send_data(CH_NL);
        end
        5, 6: send_block_comment();
        7: begin
          send_data(CH_SLASH);
          send_data(code_char());
        end
        8: repeat ($urandom_range(1, 4)) send_data(any_byte());
        default: repeat ($urandom_range(1, 8)) send_data(code_char());
      endcase
    end
    // Break some streams off in the middle of a construct.
    case ($urandom_range(0, 7))
      0: begin
        send_data(CH_SLASH);
        send_data(CH_STAR);
        repeat ($urandom_range(0, 4)) send_data(code_char());
      end
      1: send_data(CH_SLASH);
      2: begin
        send_data(CH_DQ);
        send_data(code_char());
      end
      3: begin
        send_data(CH_SLASH);
        send_data(CH_SLASH);
      end
      default: ;
    endcase
    send_word(ACT_END, any_byte());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_plain_bytes();
    send_data(8'h00);
    send_data(8'hFF);
  endtask

  // 'backslash-quote' and "backslash-quote slash": escapes and a slash inside a string.
  task automatic test_literals();
    send_data(CH_SQ);
    send_data(CH_BSL);
    send_data(CH_SQ);
    send_data(CH_SQ);
    send_data(CH_DQ);
    send_data(CH_BSL);
    send_data(CH_DQ);
    send_data(CH_SLASH);
    send_data(CH_DQ);
  endtask

  // A slash released with the next byte, then a slash flushed by end of stream.
  task automatic test_held_slash();
    send_data(CH_SLASH);
    send_data(8'h78);
    send_data(CH_SLASH);
    send_word(ACT_END, 8'hFF);
  endtask

  // Line comment, block comment with a newline and a double star, then an open
  // block comment on line 3 cut off by end of stream.
  task automatic test_comments();
    send_data(CH_SLASH);
    send_data(CH_SLASH);
    send_data(CH_NL);
    send_data(CH_SLASH);
    send_data(CH_STAR);
    send_data(CH_NL);
    send_data(CH_STAR);
    send_data(CH_STAR);
    send_data(CH_SLASH);
    send_data(CH_SLASH);
    send_data(CH_STAR);
    send_word(ACT_END, 8'h00);
  endtask

  task automatic test_random_streams();
    int goal;
    goal = words_sent + RANDOM_WORDS;
    while (words_sent < goal) begin
      send_random_stream();
      if ($urandom_range(0, 7) == 0) wait_for_drain();
    end
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    action    <= ACT_DATA;
    in_byte   <= 8'h00;
    scan_mode   = M_NORMAL;
    line_no     = 32'd1;
    block_start = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_plain_bytes();
    wait_for_drain();
    test_literals();
    wait_for_drain();
    test_held_slash();
    wait_for_drain();
    test_comments();
    wait_for_drain();
    test_random_streams();
    wait_for_drain();
    // Give a stray extra result time to show up.
    repeat (8) @(posedge clk);

    $display("Sent %0d words in %0d streams; checked %0d results", words_sent, streams_ended,
             results_checked);
    $display("Covered literals with escapes, held slashes, line and block comments, open ends");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/ccs_pkg.sv
design/ccs_front.sv
design/ccs_queue.sv
design/ccs_back.sv
design/c_comment_stripper.sv
tb/testbench.sv
